>>> rtl/core/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants of the UTF-8 to UCS-2 byte stream decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 16;
    localparam int unsigned CountW = 3;

    // Replacement character '?'
    localparam logic [CodeW-1:0] REPL_CHAR    = 16'h003F;
    // Largest value that may still take six more bits
    localparam logic [CodeW-1:0] SHIFT_LIMIT  = 16'h03FF;
    localparam logic [CodeW-1:0] SURR_LOW     = 16'hD800;
    localparam logic [CodeW-1:0] SURR_HIGH    = 16'hDFFF;
    localparam logic [CodeW-1:0] NONCHAR_FFFE = 16'hFFFE;
    localparam logic [CodeW-1:0] NONCHAR_FFFF = 16'hFFFF;

    // Latin-1 substitutes in eight-bit mode
    localparam logic [CodeW-1:0] LEFT_QUOTE   = 16'h2018;
    localparam logic [CodeW-1:0] RIGHT_QUOTE  = 16'h2019;
    localparam logic [CodeW-1:0] HYPHEN       = 16'h2010;
    localparam logic [CodeW-1:0] MINUS_SIGN   = 16'h2212;
    localparam logic [CodeW-1:0] BACKTICK     = 16'h0060;
    localparam logic [CodeW-1:0] APOSTROPHE   = 16'h0027;
    localparam logic [CodeW-1:0] DASH         = 16'h002D;

    // Registered input byte
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
    } u2u_item_t;

    // Decode result for the byte held in the input register
    typedef struct packed {
        logic              emit;
        logic [CodeW-1:0]  code;
        logic [CountW-1:0] pending;
    } u2u_result_t;

endpackage

>>> rtl/core/u2u_in_stage.sv
// ----------------------------------------------------------------------------
// u2u_in_stage
// Input register: holds one byte until the decode step consumes it.
// ----------------------------------------------------------------------------
module u2u_in_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [u2u_pkg::ByteW-1:0] s_tdata,
    input  logic                   advance,
    output u2u_pkg::u2u_item_t     item
);
    import u2u_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] data_reg;

    // Free slot, or the held byte leaves this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

>>> rtl/core/u2u_step.sv
// ----------------------------------------------------------------------------
// u2u_step
// Decode step: running sequence state and the per-byte update logic.
// ----------------------------------------------------------------------------
module u2u_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  u2u_pkg::u2u_item_t  item,
    input  logic                advance,
    input  logic                eight_bit_mode,
    output u2u_pkg::u2u_result_t result
);
    import u2u_pkg::*;

    logic [CountW-1:0] pending_reg;
    logic [CountW-1:0] pending_next;
    logic [CodeW-1:0]  partial_reg;
    logic [CodeW-1:0]  partial_next;
    logic              emit;
    logic [CountW-1:0] shamt;
    logic [6:0]        top_bits;
    logic [CodeW-1:0]  work;
    logic [CodeW-1:0]  mapped;

    // Next sequence state for the held byte
    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        shamt        = 3'd7 - pending_reg;
        top_bits     = item.data[6:0] >> shamt;
        work         = partial_reg;
        if (!item.data[7]) begin
            // ASCII: pass through, drop any partial sequence
            partial_next = {8'h00, item.data};
            pending_next = '0;
            emit         = 1'b1;
        end else if (!item.data[6]) begin
            // Continuation byte
            if (pending_reg == '0) begin
                partial_next = REPL_CHAR;
                emit         = 1'b1;
            end else begin
                // overlong: nothing assembled and no payload in the top bits
                if (partial_reg == '0 && top_bits == '0) begin
                    work = REPL_CHAR;
                end
                if (work > SHIFT_LIMIT) begin
                    work = REPL_CHAR;
                end else begin
                    work = {work[CodeW-7:0], item.data[5:0]};
                end
                if ((work >= SURR_LOW && work <= SURR_HIGH) ||
                    work == NONCHAR_FFFE || work == NONCHAR_FFFF) begin
                    work = REPL_CHAR;
                end
                partial_next = work;
                pending_next = pending_reg - 3'd1;
                emit         = (pending_reg == 3'd1);
            end
        end else if (!item.data[5]) begin
            pending_next = 3'd1;
            partial_next = {11'd0, item.data[4:0]};
            if (item.data[4:1] == 4'd0) begin
                partial_next = REPL_CHAR;
            end
        end else if (!item.data[4]) begin
            pending_next = 3'd2;
            partial_next = {12'd0, item.data[3:0]};
        end else if (!item.data[3]) begin
            pending_next = 3'd3;
            partial_next = {13'd0, item.data[2:0]};
        end else if (!item.data[2]) begin
            pending_next = 3'd4;
            partial_next = {14'd0, item.data[1:0]};
        end else if (!item.data[1]) begin
            pending_next = 3'd5;
            partial_next = {15'd0, item.data[0]};
        end else begin
            // 0xFE and 0xFF are never valid leads
            partial_next = REPL_CHAR;
            pending_next = '0;
            emit         = 1'b1;
        end
    end

    // Latin-1 substitution for wide values in eight-bit mode
    always_comb begin
        mapped = partial_next;
        if (eight_bit_mode && partial_next[CodeW-1:8] != '0) begin
            case (partial_next)
                LEFT_QUOTE:  mapped = BACKTICK;
                RIGHT_QUOTE: mapped = APOSTROPHE;
                HYPHEN:      mapped = DASH;
                MINUS_SIGN:  mapped = DASH;
                default:     mapped = REPL_CHAR;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            partial_reg <= '0;
        end else if (advance) begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

    assign result.emit    = item.valid && emit;
    assign result.code    = mapped;
    assign result.pending = pending_reg;

endmodule

>>> rtl/core/u2u_out_stage.sv
// ----------------------------------------------------------------------------
// u2u_out_stage
// Result register: holds a decoded character until the sink takes it.
// ----------------------------------------------------------------------------
module u2u_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [u2u_pkg::CodeW-1:0] code,
    output logic                      free,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [u2u_pkg::CodeW-1:0] m_tdata
);
    import u2u_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [CodeW-1:0] data_reg;

    // Room for a new result this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= code;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> rtl/core/utf8_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Byte stream UTF-8 decoder producing UCS-2 characters, with an optional
// Latin-1 substitution mode.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                     meaning
//  s_        in   [7:0]  in_byte            one raw UTF-8 byte
//  m_        out  [15:0] code_point         decoded character, '?' on error
//  cfg_      in   cfg_wdata = eight_bit_mode
//
//  One byte per cycle sustained while m_ does not stall; a byte passes the
//  input register, decode logic and result register on its way to m_.
//  Bytes that complete no character produce no transaction on m_.
//  A stall on m_ holds a byte in the input register only if it emits.
//  Reset clears sequence state, the valid flags of both stage registers and the mode bit.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,     // [0] eight_bit_mode
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [u2u_pkg::ByteW-1:0] s_tdata,       // [7:0] in_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [u2u_pkg::CodeW-1:0] m_tdata        // [15:0] code_point
);
    import u2u_pkg::*;

    logic        mode_reg;
    logic        advance;
    logic        out_free;
    u2u_item_t   item;
    u2u_result_t result;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Held byte moves on unless its result has nowhere to go
    assign advance = item.valid && (!result.emit || out_free);

    u2u_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .item     (item)
    );

    u2u_step u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item           (item),
        .advance        (advance),
        .eight_bit_mode (mode_reg),
        .result         (result)
    );

    u2u_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && result.emit),
        .code     (result.code),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // At most five continuation bytes are ever expected
    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        result.pending <= 3'd5)
        else $error("pending continuation count out of range");

    // An emitting byte must wait while the result register is blocked
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (item.valid && result.emit && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while emitting byte is stalled");

    // A consumed emitting byte shows up on the result channel next cycle
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.emit) |=> m_tvalid)
        else $error("decoded character lost");
`endif

endmodule
